>>> src/cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types and constants for the cartridge bank mapper and its decoder.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int MAX_ROM_BANKS_DEFAULT = 512;

   localparam int BANK_W      = 9;
   localparam int CLOCK_REGS  = 5;

   // Mapper styles.
   localparam logic [1:0] STYLE_ROM_ONLY = 2'd0;
   localparam logic [1:0] STYLE_MBC1     = 2'd1;
   localparam logic [1:0] STYLE_MBC3     = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_ROM_READ   = 3'd0;
   localparam logic [2:0] KIND_RAM_READ   = 3'd1;
   localparam logic [2:0] KIND_RAM_WRITE  = 3'd2;
   localparam logic [2:0] KIND_CLOCK_READ = 3'd3;
   localparam logic [2:0] KIND_OPEN_BUS   = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAPPER_MODE    = 2'd0;
   localparam logic [1:0] CSR_HAS_CART_RAM   = 2'd1;
   localparam logic [1:0] CSR_ROM_BANK_MASK  = 2'd2;
   localparam logic [1:0] CSR_RAM_BANK_COUNT = 2'd3;

   localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] CLOCK_BANK_LO  = 8'h08;
   localparam logic [7:0] CLOCK_BANK_HI  = 8'h0C;

   typedef struct packed {
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
      logic        func;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [22:0] mem_address;
      logic [7:0]  write_byte;
      logic [7:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic [1:0] mapper_mode;
      logic       has_cart_ram;
      logic [8:0] rom_bank_mask;
      logic [4:0] ram_bank_count;
   } cfg_type;

   typedef struct packed {
      logic [BANK_W-1:0]                rom_bank;
      logic [7:0]                       ram_bank;
      logic                             ram_enabled;
      logic                             banking_mode;
      logic [CLOCK_REGS-1:0][7:0]       clock_regs;
   } mapper_state_type;

endpackage

>>> src/cbm_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper decoder
// Decodes one bus access against the bank state: gives the result beat, if
// any, and the bank state that follows the access.
// ----------------------------------------------------------------------------
module cbm_decode #(
   parameter int MaxRomBanks = cbm_pkg::MAX_ROM_BANKS_DEFAULT
) (
   input  cbm_pkg::cfg_type          cfg,
   input  cbm_pkg::mapper_state_type state_cur,
   input  cbm_pkg::req_type          item,
   output cbm_pkg::mapper_state_type state_nxt,
   output logic                      emit,
   output cbm_pkg::rsp_type          rsp
);

   localparam logic [8:0] BankLimit = 9'(MaxRomBanks - 1);

   logic [3:0] page;
   logic       mbc1;
   logic       mbc3;
   logic       ram_on;
   logic [8:0] eff_mask;
   logic [8:0] bank_tmp;
   logic [8:0] read_bank;
   logic       clock_bank;
   logic       clock_in_range;
   logic [2:0] clock_idx;
   logic       ram_window;
   logic [22:0] ram_addr;

   assign page           = item.bus_address[15:12];
   assign mbc1           = (cfg.mapper_mode == cbm_pkg::STYLE_MBC1);
   assign mbc3           = (cfg.mapper_mode == cbm_pkg::STYLE_MBC3);
   assign ram_on         = cfg.has_cart_ram & state_cur.ram_enabled;
   assign eff_mask       = cfg.rom_bank_mask & BankLimit;
   assign clock_bank     = mbc3 && (state_cur.ram_bank >= cbm_pkg::CLOCK_BANK_LO);
   assign clock_in_range = clock_bank && (state_cur.ram_bank <= cbm_pkg::CLOCK_BANK_HI);
   assign clock_idx      = state_cur.ram_bank[2:0];
   assign ram_window     = (page == 4'hA) || (page == 4'hB);
   assign read_bank      = (mbc1 && state_cur.banking_mode) ?
                           {4'd0, state_cur.rom_bank[4:0]} : state_cur.rom_bank;

   always_comb begin
      ram_addr = {10'd0, item.bus_address[12:0]};
      if ((state_cur.banking_mode || !mbc1) &&
          ({1'b0, state_cur.ram_bank} < {4'd0, cfg.ram_bank_count})) begin
         ram_addr = {5'd0, state_cur.ram_bank[4:0], item.bus_address[12:0]};
      end
   end

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      rsp       = '0;
      bank_tmp  = state_cur.rom_bank;
      if (item.func) begin
         priority if (page <= 4'd1) begin
            if ((mbc1 || mbc3) && cfg.has_cart_ram) begin
               state_nxt.ram_enabled = (item.bus_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            end
         end else if (page <= 4'd3) begin
            if (mbc1) begin
               bank_tmp = {state_cur.rom_bank[8:7], state_cur.rom_bank[6:5],
                           item.bus_data[4:0]} & 9'h07F;
               if (bank_tmp[4:0] == 5'd0) begin
                  bank_tmp = bank_tmp + 9'd1;
               end
            end else if (mbc3) begin
               bank_tmp = {2'd0, item.bus_data[6:0]};
               if (bank_tmp == 9'd0) begin
                  bank_tmp = 9'd1;
               end
            end
            state_nxt.rom_bank = bank_tmp & eff_mask;
         end else if (page <= 4'd5) begin
            if (mbc1) begin
               state_nxt.ram_bank = {6'd0, item.bus_data[1:0]};
               state_nxt.rom_bank = {2'd0, item.bus_data[1:0], state_cur.rom_bank[4:0]}
                                    & eff_mask;
            end else if (mbc3) begin
               state_nxt.ram_bank = item.bus_data;
            end
         end else if (page <= 4'd7) begin
            state_nxt.banking_mode = item.bus_data[0];
         end else if (ram_window && ram_on) begin
            if (clock_bank) begin
               for (int i = 0; i < cbm_pkg::CLOCK_REGS; i++) begin
                  if (clock_in_range && (clock_idx == 3'(i))) begin
                     state_nxt.clock_regs[i] = item.bus_data;
                  end
               end
            end else if (cfg.ram_bank_count != 5'd0) begin
               emit            = 1'b1;
               rsp.result_kind = cbm_pkg::KIND_RAM_WRITE;
               rsp.mem_address = ram_addr;
               rsp.write_byte  = item.bus_data;
            end
         end
      end else begin
         priority if (page <= 4'd3) begin
            emit            = 1'b1;
            rsp.result_kind = cbm_pkg::KIND_ROM_READ;
            rsp.mem_address = {7'd0, item.bus_address};
         end else if (page <= 4'd7) begin
            emit            = 1'b1;
            rsp.result_kind = cbm_pkg::KIND_ROM_READ;
            rsp.mem_address = {read_bank, item.bus_address[13:0]};
         end else if (ram_window) begin
            emit = 1'b1;
            if (!ram_on || (clock_bank && !clock_in_range) ||
                (!clock_bank && (cfg.ram_bank_count == 5'd0))) begin
               rsp.result_kind = cbm_pkg::KIND_OPEN_BUS;
               rsp.read_byte   = cbm_pkg::OPEN_BUS_BYTE;
            end else if (clock_bank) begin
               rsp.result_kind = cbm_pkg::KIND_CLOCK_READ;
               for (int i = 0; i < cbm_pkg::CLOCK_REGS; i++) begin
                  if (clock_idx == 3'(i)) begin
                     rsp.read_byte = state_cur.clock_regs[i];
                  end
               end
            end else begin
               rsp.result_kind = cbm_pkg::KIND_RAM_READ;
               rsp.mem_address = ram_addr;
            end
         end
      end
   end

endmodule

>>> src/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Bank controller for a cartridge bus in ROM only, MBC1 or MBC3 style. It
// maps bus reads to ROM or RAM addresses, clock register data or open bus,
// maps RAM writes, and tracks the bank registers written by the bus.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Beat
//   req      in         req_valid / req_ready  req_payload (cbm_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_payload (cbm_pkg::rsp_type)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One beat per cycle is accepted while the decoder is not held. A beat goes
// into an input register and is decoded from there; its result, if any, is
// loaded into the output register when that register is free. Bank state
// changes as the beat leaves the input register, so the next beat sees it at
// once. A stalled result holds the decoder only when the beat in decode has a
// result too.
// Reset puts the bank registers and the configuration to their start values.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper #(
   parameter int MaxRomBanks = cbm_pkg::MAX_ROM_BANKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbm_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata
);

   localparam int RomBankW = $clog2(MaxRomBanks);

   cbm_pkg::cfg_type          cfg_ff;
   cbm_pkg::cfg_type          cfg_in;
   cbm_pkg::req_type          item_ff;
   logic                      item_valid_ff;
   logic                      item_valid_in;
   cbm_pkg::rsp_type          rsp_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RomBankW-1:0]       rom_bank_ff;
   logic [RomBankW-1:0]       rom_bank_in;
   logic [7:0]                ram_bank_ff;
   logic                      ram_enabled_ff;
   logic                      banking_mode_ff;
   logic [cbm_pkg::CLOCK_REGS-1:0][7:0] clock_regs_ff;
   cbm_pkg::mapper_state_type state_cur;
   cbm_pkg::mapper_state_type state_nxt;
   cbm_pkg::rsp_type          dec_rsp;
   logic                      dec_emit;
   logic                      out_free;
   logic                      advance;

   assign state_cur.rom_bank     = cbm_pkg::BANK_W'(rom_bank_ff);
   assign state_cur.ram_bank     = ram_bank_ff;
   assign state_cur.ram_enabled  = ram_enabled_ff;
   assign state_cur.banking_mode = banking_mode_ff;
   assign state_cur.clock_regs   = clock_regs_ff;

   cbm_decode #(
      .MaxRomBanks(MaxRomBanks)
   ) u_decode (
      .cfg      (cfg_ff),
      .state_cur(state_cur),
      .item     (item_ff),
      .state_nxt(state_nxt),
      .emit     (dec_emit),
      .rsp      (dec_rsp)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign advance       = item_valid_ff && (!dec_emit || out_free);
   assign req_ready     = !item_valid_ff || advance;
   assign item_valid_in = req_valid || (item_valid_ff && !advance);
   assign rsp_valid_in  = out_free ? (advance && dec_emit) : rsp_valid_ff;
   assign rom_bank_in   = state_nxt.rom_bank[RomBankW-1:0];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cbm_pkg::CSR_MAPPER_MODE:    cfg_in.mapper_mode    = csr_wdata[1:0];
            cbm_pkg::CSR_HAS_CART_RAM:   cfg_in.has_cart_ram   = csr_wdata[0];
            cbm_pkg::CSR_ROM_BANK_MASK:  cfg_in.rom_bank_mask  = csr_wdata;
            cbm_pkg::CSR_RAM_BANK_COUNT: cfg_in.ram_bank_count = csr_wdata[4:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mapper_mode    <= cbm_pkg::STYLE_ROM_ONLY;
         cfg_ff.has_cart_ram   <= 1'b0;
         cfg_ff.rom_bank_mask  <= 9'd1;
         cfg_ff.ram_bank_count <= 5'd0;
         item_valid_ff         <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         rom_bank_ff           <= RomBankW'(1);
         ram_bank_ff           <= 8'd0;
         ram_enabled_ff        <= 1'b0;
         banking_mode_ff       <= 1'b0;
         clock_regs_ff         <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            rom_bank_ff     <= rom_bank_in;
            ram_bank_ff     <= state_nxt.ram_bank;
            ram_enabled_ff  <= state_nxt.ram_enabled;
            banking_mode_ff <= state_nxt.banking_mode;
            clock_regs_ff   <= state_nxt.clock_regs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      if (advance && dec_emit && out_free) begin
         rsp_ff <= dec_rsp;
      end
   end

endmodule

>>> test/cbm_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper access checker
// Watches the request, result and register ports of the mapper. It keeps its
// own copy of the bank registers and settings, works out the result of every
// accepted bus beat, and compares each result beat field by field with the
// oldest outstanding prediction. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module cbm_access_checker
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   output int unsigned pending,
   output int unsigned errors,
   output int unsigned results_checked
);

   cfg_type          mapper_cfg;
   mapper_state_type bank_state;
   rsp_type          expected_results[$];
   int unsigned      failures = 0;
   int unsigned      checked = 0;

   function automatic logic [22:0] ram_window_offset(input logic [15:0] address);
      logic [22:0] offset;
      offset = {10'd0, address[12:0]};
      if ((bank_state.banking_mode || mapper_cfg.mapper_mode != STYLE_MBC1) &&
          bank_state.ram_bank < {3'd0, mapper_cfg.ram_bank_count}) begin
         offset = offset + {2'b00, bank_state.ram_bank, 13'd0};
      end
      return offset;
   endfunction

   // Applies one bus beat to the bank registers and returns 1 when it has a result.
   function automatic bit map_access(input req_type beat, output rsp_type result);
      logic [3:0] page;
      logic [7:0] data;
      logic       mbc1;
      logic       mbc3;
      logic       ram_on;
      logic       clock_bank;
      logic [8:0] bank;
      page       = beat.bus_address[15:12];
      data       = beat.bus_data;
      mbc1       = (mapper_cfg.mapper_mode == STYLE_MBC1);
      mbc3       = (mapper_cfg.mapper_mode == STYLE_MBC3);
      ram_on     = mapper_cfg.has_cart_ram && bank_state.ram_enabled;
      clock_bank = mbc3 && (bank_state.ram_bank >= CLOCK_BANK_LO);
      result     = '0;

      if (beat.func) begin
         if (page <= 4'h1) begin
            if ((mbc1 || mbc3) && mapper_cfg.has_cart_ram)
               bank_state.ram_enabled = (data[3:0] == RAM_ENABLE_KEY);
         end else if (page <= 4'h3) begin
            if (mbc1) begin
               bank_state.rom_bank = {2'b00, bank_state.rom_bank[6:5], data[4:0]};
               if (data[4:0] == 5'd0)
                  bank_state.rom_bank = bank_state.rom_bank + 9'd1;
            end else if (mbc3) begin
               bank_state.rom_bank = {2'b00, data[6:0]};
               if (data[6:0] == 7'd0)
                  bank_state.rom_bank = 9'd1;
            end
            bank_state.rom_bank = bank_state.rom_bank & mapper_cfg.rom_bank_mask;
         end else if (page <= 4'h5) begin
            if (mbc1) begin
               bank_state.ram_bank = {6'd0, data[1:0]};
               bank_state.rom_bank = {2'b00, data[1:0], bank_state.rom_bank[4:0]} &
                                     mapper_cfg.rom_bank_mask;
            end else if (mbc3) begin
               bank_state.ram_bank = data;
            end
         end else if (page <= 4'h7) begin
            bank_state.banking_mode = data[0];
         end else if (page == 4'hA || page == 4'hB) begin
            if (!ram_on)
               return 1'b0;
            if (clock_bank) begin
               if (bank_state.ram_bank <= CLOCK_BANK_HI)
                  bank_state.clock_regs[3'(bank_state.ram_bank - CLOCK_BANK_LO)] = data;
               return 1'b0;
            end
            if (mapper_cfg.ram_bank_count == 5'd0)
               return 1'b0;
            result.result_kind = KIND_RAM_WRITE;
            result.mem_address = ram_window_offset(beat.bus_address);
            result.write_byte  = data;
            return 1'b1;
         end
         return 1'b0;
      end

      if (page <= 4'h3) begin
         result.result_kind = KIND_ROM_READ;
         result.mem_address = {7'd0, beat.bus_address};
         return 1'b1;
      end
      if (page <= 4'h7) begin
         bank = (mbc1 && bank_state.banking_mode) ? {4'd0, bank_state.rom_bank[4:0]}
                                                 : bank_state.rom_bank;
         result.result_kind = KIND_ROM_READ;
         result.mem_address = {bank, beat.bus_address[13:0]};
         return 1'b1;
      end
      if (page == 4'hA || page == 4'hB) begin
         if (!ram_on || (clock_bank && bank_state.ram_bank > CLOCK_BANK_HI) ||
             (!clock_bank && mapper_cfg.ram_bank_count == 5'd0)) begin
            result.result_kind = KIND_OPEN_BUS;
            result.read_byte   = OPEN_BUS_BYTE;
         end else if (clock_bank) begin
            result.result_kind = KIND_CLOCK_READ;
            result.read_byte   =
               bank_state.clock_regs[3'(bank_state.ram_bank - CLOCK_BANK_LO)];
         end else begin
            result.result_kind = KIND_RAM_READ;
            result.mem_address = ram_window_offset(beat.bus_address);
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      bit      produced;
      if (reset) begin
         mapper_cfg          = '{STYLE_ROM_ONLY, 1'b0, 9'd1, 5'd0};
         bank_state          = '0;
         bank_state.rom_bank = 9'd1;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected result beat: kind %0d addr %h wbyte %h rbyte %h",
                           $time, got.result_kind, got.mem_address, got.write_byte,
                           got.read_byte);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (got.result_kind !== want.result_kind ||
                   got.mem_address !== want.mem_address ||
                   got.write_byte !== want.write_byte ||
                   got.read_byte !== want.read_byte) begin
                  failures++;
                  if (failures <= 10)
                     $display({"%0t: result %0d mismatch: expected kind %0d addr %h ",
                               "wbyte %h rbyte %h, got kind %0d addr %h wbyte %h rbyte %h"},
                              $time, checked, want.result_kind, want.mem_address,
                              want.write_byte, want.read_byte, got.result_kind,
                              got.mem_address, got.write_byte, got.read_byte);
               end
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_MAPPER_MODE:    mapper_cfg.mapper_mode    = csr_wdata[1:0];
               CSR_HAS_CART_RAM:   mapper_cfg.has_cart_ram   = csr_wdata[0];
               CSR_ROM_BANK_MASK:  mapper_cfg.rom_bank_mask  = csr_wdata;
               CSR_RAM_BANK_COUNT: mapper_cfg.ram_bank_count = csr_wdata[4:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            produced = map_access(req_payload, want);
            if (produced)
               expected_results.push_back(want);
         end
      end
      pending         <= expected_results.size();
      errors          <= failures;
      results_checked <= checked;
   end

endmodule

>>> test/tb_cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives bus beats into the mapper under a series of mapper settings: a short
// directed run through the bank rules, then random register sessions and
// accesses with random gaps on both channels, one long result stall and
// drained pauses. The access checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper;
   import cbm_pkg::*;

   localparam logic [1:0] STYLE_UNUSED      = 2'd3;
   localparam logic       BUS_READ          = 1'b0;
   localparam logic       BUS_WRITE         = 1'b1;
   localparam int         SETTLE_CYCLES     = 6;
   localparam int         LONG_STALL_CYCLES = 60;
   localparam int         PHASES            = 14;
   localparam int         PHASE_ITEMS       = 105;
   localparam int         STALL_PHASE       = 5;
   localparam int         PAUSE_PHASE       = 8;

   typedef enum int {
      RGN_ENABLE, RGN_ROM_BANK, RGN_RAM_BANK, RGN_MODE,
      RGN_ROM_LOW, RGN_ROM_HIGH, RGN_RAM, RGN_UNMAPPED
   } bus_region_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MAPPER_MODE;
   logic [8:0]  csr_wdata = '0;
   int unsigned pending;
   int unsigned errors;
   int unsigned results_checked;
   int unsigned items_sent = 0;
   int unsigned settings_used = 0;
   int unsigned stall_requests = 0;
   int unsigned stalls_done = 0;
   bit          no_idle = 1'b0;

   always #5 clock = ~clock;

   cartridge_bank_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   cbm_access_checker access_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending         (pending),
      .errors          (errors),
      .results_checked (results_checked)
   );

   function automatic logic [15:0] region_address(input bus_region_type region);
      case (region)
         RGN_ENABLE:   return 16'($urandom_range(16'h1FFF));
         RGN_ROM_BANK: return 16'($urandom_range(16'h3FFF, 16'h2000));
         RGN_RAM_BANK: return 16'($urandom_range(16'h5FFF, 16'h4000));
         RGN_MODE:     return 16'($urandom_range(16'h7FFF, 16'h6000));
         RGN_ROM_LOW:  return 16'($urandom_range(16'h3FFF));
         RGN_ROM_HIGH: return 16'($urandom_range(16'h7FFF, 16'h4000));
         RGN_RAM:      return 16'($urandom_range(16'hBFFF, 16'hA000));
         default:      return $urandom_range(1) ? 16'($urandom_range(16'h9FFF, 16'h8000))
                                                : 16'($urandom_range(16'hFFFF, 16'hC000));
      endcase
   endfunction

   function automatic logic [7:0] bank_data(input bus_region_type region);
      case (region)
         RGN_ENABLE:
            return $urandom_range(1) ? {4'($urandom), RAM_ENABLE_KEY} : 8'($urandom);
         RGN_RAM_BANK:
            case ($urandom_range(2))
               0:       return 8'($urandom_range(15));
               1:       return CLOCK_BANK_LO + 8'($urandom_range(5));
               default: return 8'($urandom);
            endcase
         default:
            return 8'($urandom);
      endcase
   endfunction

   task automatic send_access(input logic [15:0] address, input logic [7:0] data,
                              input logic write);
      int gap;
      gap = no_idle ? 0 : $urandom_range(3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{bus_address: address, bus_data: data, func: write};
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type setting);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_MAPPER_MODE;
      csr_wdata <= 9'(setting.mapper_mode);
      @(posedge clock);
      csr_index <= CSR_HAS_CART_RAM;
      csr_wdata <= 9'(setting.has_cart_ram);
      @(posedge clock);
      csr_index <= CSR_ROM_BANK_MASK;
      csr_wdata <= setting.rom_bank_mask;
      @(posedge clock);
      csr_index <= CSR_RAM_BANK_COUNT;
      csr_wdata <= 9'(setting.ram_bank_count);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin : receiver
      int gap;
      wait (reset === 1'b0);
      forever begin
         if (stall_requests != stalls_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
            stalls_done++;
         end else begin
            gap = no_idle ? 0 : $urandom_range(3);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
            while (rsp_valid !== 1'b1) @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_cartridge_bank_mapper failed");
      $finish;
   end

   initial begin : stimulus
      cfg_type        setting;
      bus_region_type region;
      int unsigned    phase_start;
      int             accesses;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_config('{STYLE_MBC1, 1'b1, 9'h07F, 5'd4});
      send_access(16'h0000, 8'h00, BUS_READ);
      send_access(16'h7FFF, 8'hFF, BUS_READ);
      send_access(16'h2000, 8'h00, BUS_WRITE);
      send_access(16'h3FFF, 8'hFF, BUS_WRITE);
      send_access(16'h4000, 8'h03, BUS_WRITE);
      send_access(16'h4000, 8'h00, BUS_READ);
      send_access(16'h6000, 8'h01, BUS_WRITE);
      send_access(16'h7FFF, 8'h00, BUS_READ);
      send_access(16'hA000, 8'h00, BUS_READ);
      send_access(16'h0000, 8'h0A, BUS_WRITE);
      send_access(16'hBFFF, 8'h5A, BUS_WRITE);
      send_access(16'hA123, 8'h00, BUS_READ);
      send_access(16'h8000, 8'h00, BUS_READ);
      send_access(16'hFFFF, 8'hFF, BUS_WRITE);

      apply_config('{STYLE_MBC3, 1'b1, 9'h1FF, 5'd0});
      send_access(16'h1FFF, 8'hFA, BUS_WRITE);
      send_access(16'h4000, CLOCK_BANK_LO, BUS_WRITE);
      send_access(16'hA000, 8'hFF, BUS_WRITE);
      send_access(16'hB000, 8'h00, BUS_READ);
      send_access(16'h5FFF, CLOCK_BANK_HI, BUS_WRITE);
      send_access(16'hBFFF, 8'h00, BUS_READ);
      send_access(16'h4000, 8'h0D, BUS_WRITE);
      send_access(16'hA000, 8'h00, BUS_READ);
      send_access(16'h4000, 8'h00, BUS_WRITE);
      send_access(16'hA000, 8'h00, BUS_READ);
      send_access(16'h2000, 8'h80, BUS_WRITE);
      send_access(16'h7FFF, 8'h00, BUS_READ);

      apply_config('{STYLE_UNUSED, 1'b1, 9'h000, 5'd16});
      send_access(16'h2000, 8'h55, BUS_WRITE);
      send_access(16'h4000, 8'h00, BUS_READ);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: setting = '{STYLE_ROM_ONLY, 1'b0, 9'h000, 5'd0};
            1: setting = '{STYLE_MBC1, 1'b1, 9'h1FF, 5'd16};
            2: setting = '{STYLE_MBC3, 1'b1, 9'h1FF, 5'd16};
            3: setting = '{STYLE_MBC3, 1'b0, 9'h001, 5'd1};
            default: begin
               case ($urandom_range(9))
                  0:             setting.mapper_mode = STYLE_ROM_ONLY;
                  1, 2, 3, 4:    setting.mapper_mode = STYLE_MBC1;
                  5, 6, 7, 8:    setting.mapper_mode = STYLE_MBC3;
                  default:       setting.mapper_mode = STYLE_UNUSED;
               endcase
               setting.has_cart_ram = ($urandom_range(4) != 0);
               case ($urandom_range(4))
                  0:       setting.rom_bank_mask = 9'h1FF;
                  1, 2:    setting.rom_bank_mask = 9'h1FF >> $urandom_range(8);
                  3:       setting.rom_bank_mask = 9'($urandom_range(511));
                  default: setting.rom_bank_mask = 9'($urandom_range(1));
               endcase
               case ($urandom_range(3))
                  0:       setting.ram_bank_count = 5'd16;
                  1:       setting.ram_bank_count = 5'($urandom_range(16));
                  2:       setting.ram_bank_count = 5'($urandom_range(4, 1));
                  default: setting.ram_bank_count = 5'($urandom_range(1));
               endcase
            end
         endcase
         apply_config(setting);
         no_idle = (phase % 3 == 1);
         phase_start = items_sent;

         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(9) < 7) begin
               send_access(region_address(RGN_ENABLE), bank_data(RGN_ENABLE), BUS_WRITE);
               send_access(region_address(RGN_ROM_BANK), bank_data(RGN_ROM_BANK),
                           BUS_WRITE);
               send_access(region_address(RGN_RAM_BANK), bank_data(RGN_RAM_BANK),
                           BUS_WRITE);
               if ($urandom_range(1))
                  send_access(region_address(RGN_MODE), bank_data(RGN_MODE), BUS_WRITE);
               accesses = $urandom_range(8, 3);
               repeat (accesses) begin
                  case ($urandom_range(4))
                     0:       region = RGN_ROM_LOW;
                     1:       region = RGN_ROM_HIGH;
                     default: region = RGN_RAM;
                  endcase
                  send_access(region_address(region), 8'($urandom),
                              (region == RGN_RAM) ? 1'($urandom)
                                                  : 1'($urandom_range(3) == 0));
               end
            end else begin
               region = bus_region_type'($urandom_range(int'(RGN_UNMAPPED)));
               send_access(region_address(region), bank_data(region), 1'($urandom));
            end
         end

         if (phase == STALL_PHASE) begin
            stall_requests++;
            no_idle = 1'b1;
            repeat (40) send_access(region_address(RGN_ROM_HIGH), 8'($urandom), BUS_READ);
            no_idle = 1'b0;
         end
         if (phase == PAUSE_PHASE)
            drain_results();
      end

      drain_results();
      $display("Sent %0d bus beats under %0d mapper settings, %0d result beats compared.",
               items_sent, settings_used, results_checked);
      $display("Failures seen: %0d.", errors);
      if (errors == 0 && pending == 0)
         $display("tb_cartridge_bank_mapper passed");
      else
         $display("tb_cartridge_bank_mapper failed");
      $finish;
   end

endmodule
